FILE: design/pta_pkg.sv
// Shared types and codes for the partition table fit allocator.
// No dependencies.
package pta_pkg;

	typedef enum logic [1:0] {
		OP_CREATE = 2'd0,
		OP_GROW   = 2'd1,
		OP_DELETE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_SIZE  = 3'd1,
		ST_NAME_DUP  = 3'd2,
		ST_FULL      = 3'd3,
		ST_EXT_TWICE = 3'd4,
		ST_NO_SPACE  = 3'd5,
		ST_NOT_FOUND = 3'd6,
		ST_OVER      = 3'd7
	} status_t;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	localparam logic REG_DISK = 1'b0;
	localparam logic REG_FIT  = 1'b1;

	localparam logic [30:0] DISK_RESET = 31'd10485760;

	typedef struct packed {
		op_t                operation;
		logic [31:0]        name_tag;
		logic signed [31:0] amount;
		logic               part_kind;
		logic [1:0]         fit_tag;
	} cmd_t;

	typedef struct packed {
		status_t     status;
		logic [30:0] placed_start;
		logic [1:0]  slot_index;
	} result_t;

	typedef struct packed {
		logic        used;
		logic [30:0] start;
		logic [30:0] size;
		logic [31:0] name;
		logic        ext;
		logic [1:0]  fit;
	} entry_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_FROM_LEFT,
		CELL_FROM_RIGHT,
		CELL_RESIZE
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		entry_t   load;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_FIT,
		S_PLACE
	} state_t;

endpackage

FILE: design/partition_table_fit_allocator.sv
// Partition table allocator. Grow, delete and creates rejected on size, full table, second
// extended or name give their result word from the look state; a create that reaches the
// gap scan (placed or no space) goes on to the fit state, which scans the cells in order, then to place.
// One command at a time: busy is high until the result word shows, so the next command can
// be taken in the result cycle; the receiver cannot stall. Reset empties the table and
// restores disk_bytes and fit_policy defaults. Depends on pta_pkg and pta_cell.
module partition_table_fit_allocator import pta_pkg::*; #(
	parameter int SLOTS        = 4,
	parameter int HEADER_BYTES = 136
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  cmd_t        cmd,
	output logic        done,
	output result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	state_t state_q, state_d;
	cmd_t   cmd_q;
	logic [30:0] disk_q;
	logic [1:0]  fit_q;

	entry_t             ent   [SLOTS+1];
	logic [31:0]        ends  [SLOTS+1];
	logic               ends_used [SLOTS+1];
	logic signed [32:0] gap   [SLOTS];
	logic [SLOTS-1:0]   gap_ok, match, gbad, gover, used_vec;
	cell_ctl_t          ctl   [SLOTS];
	entry_t             load_entry;

	logic [SLOTS-1:0]   first_sel, at_or_after;
	logic [IDX_W-1:0]   sel_idx;
	logic               any_match, sel_bad, sel_over, ext_err;
	logic [30:0]        sel_start;

	logic [IDX_W-1:0]   k_q, pick_q;
	logic               pick_v_q;
	logic signed [32:0] pick_gap_q;
	logic [31:0]        pick_lo_q;
	logic               take;

	logic    done_d, done_q;
	result_t res_d, res_q;
	logic [31:0] idx_wide;

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;
	assign pready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_q <= DISK_RESET;
			fit_q  <= FIT_BEST;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_DISK: disk_q <= pwdata[30:0];
				REG_FIT:  fit_q  <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_DISK: prdata = {1'b0, disk_q};
			REG_FIT:  prdata = {30'd0, fit_q};
			default:  prdata = '0;
		endcase
	end

	// cell chain
	assign ends[0]         = 32'(HEADER_BYTES);
	assign ends_used[0]    = 1'b1;
	assign ent[SLOTS]      = '0;

	for (genvar j = 0; j < SLOTS; j++) begin : g_cell
		entry_t left_e;
		if (j == 0) begin : g_first
			assign left_e = '0;
		end else begin : g_rest
			assign left_e = ent[j-1];
		end
		pta_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl[j]),
			.left_entry  (left_e),
			.right_entry (ent[j+1]),
			.prev_end    (ends[j]),
			.prev_used   (ends_used[j]),
			.disk_bytes  (disk_q),
			.tag         (cmd_q.name_tag),
			.amt         (cmd_q.amount),
			.entry       (ent[j]),
			.end_addr    (ends[j+1]),
			.gap         (gap[j]),
			.gap_ok      (gap_ok[j]),
			.match       (match[j]),
			.grow_bad    (gbad[j]),
			.grow_over   (gover[j])
		);
		assign ends_used[j+1] = ent[j].used;
		assign used_vec[j]    = ent[j].used;
	end

	// lowest matching slot and the flags it selects
	always_comb begin
		logic seen;
		seen      = 1'b0;
		sel_idx   = '0;
		sel_bad   = 1'b0;
		sel_over  = 1'b0;
		sel_start = '0;
		ext_err   = 1'b0;
		for (int j = 0; j < SLOTS; j++) begin
			first_sel[j]   = match[j] && !seen;
			seen           = seen || match[j];
			at_or_after[j] = seen;
			if (first_sel[j]) begin
				sel_idx   = IDX_W'(j);
				sel_bad   = gbad[j];
				sel_over  = gover[j];
				sel_start = ent[j].start;
			end
			if (j < SLOTS - 1 && ent[j].used && ent[j].ext)
				ext_err = 1'b1;
		end
		any_match = seen;
	end

	assign take = gap_ok[k_q] && (!pick_v_q
		|| (fit_q == FIT_BEST  && gap[k_q] < pick_gap_q)
		|| (fit_q == FIT_WORST && gap[k_q] > pick_gap_q));

	assign load_entry = '{used: 1'b1, start: pick_lo_q[30:0],
		size: cmd_q.amount[30:0], name: cmd_q.name_tag,
		ext: cmd_q.part_kind, fit: cmd_q.fit_tag};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (start) state_d = S_LOOK;
			S_LOOK: begin
				if (cmd_q.operation == OP_CREATE && cmd_q.amount > 32'sd0 && !(cmd_q.part_kind
						&& ext_err) && !used_vec[SLOTS-1] && !any_match)
					state_d = S_FIT;
				else
					state_d = S_IDLE;
			end
			S_FIT:   if (k_q == IDX_W'(SLOTS - 1)) state_d = S_PLACE;
			S_PLACE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs and cell commands
	always_comb begin
		done_d = 1'b0;
		res_d  = '{status: ST_OK, placed_start: '0, slot_index: '0};
		idx_wide = '0;
		for (int j = 0; j < SLOTS; j++)
			ctl[j] = '{op: CELL_HOLD, load: load_entry};
		case (state_q)
			S_LOOK: begin
				case (cmd_q.operation)
					OP_CREATE: begin
						if (cmd_q.amount <= 32'sd0) begin
							done_d = 1'b1; res_d.status = ST_BAD_SIZE;
						end else if (cmd_q.part_kind && ext_err) begin
							done_d = 1'b1; res_d.status = ST_EXT_TWICE;
						end else if (used_vec[SLOTS-1]) begin
							done_d = 1'b1; res_d.status = ST_FULL;
						end else if (any_match) begin
							done_d = 1'b1; res_d.status = ST_NAME_DUP;
						end
					end
					OP_GROW: begin
						done_d = 1'b1;
						if (!any_match) begin
							res_d.status = ST_NOT_FOUND;
						end else if (sel_bad) begin
							res_d.status = ST_BAD_SIZE;
						end else if (sel_over) begin
							res_d.status = ST_OVER;
						end else begin
							idx_wide           = 32'(sel_idx);
							res_d.placed_start = sel_start;
							res_d.slot_index   = idx_wide[1:0];
							for (int j = 0; j < SLOTS; j++)
								if (first_sel[j]) ctl[j].op = CELL_RESIZE;
						end
					end
					OP_DELETE: begin
						done_d = 1'b1;
						if (!any_match) begin
							res_d.status = ST_NOT_FOUND;
						end else begin
							idx_wide         = 32'(sel_idx);
							res_d.slot_index = idx_wide[1:0];
							for (int j = 0; j < SLOTS; j++)
								if (at_or_after[j]) ctl[j].op = CELL_FROM_RIGHT;
						end
					end
					default: ;
				endcase
			end
			S_PLACE: begin
				done_d = 1'b1;
				if (!pick_v_q) begin
					res_d.status = ST_NO_SPACE;
				end else begin
					idx_wide           = 32'(pick_q);
					res_d.placed_start = pick_lo_q[30:0];
					res_d.slot_index   = idx_wide[1:0];
					// ends_used[j] is the used flag of the left neighbor
					for (int j = 0; j < SLOTS; j++) begin
						if (IDX_W'(j) == pick_q)
							ctl[j].op = CELL_LOAD;
						else if (IDX_W'(j) > pick_q && ends_used[j])
							ctl[j].op = CELL_FROM_LEFT;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			k_q      <= '0;
			pick_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (state_q == S_LOOK) begin
				k_q      <= '0;
				pick_v_q <= 1'b0;
			end else if (state_q == S_FIT) begin
				k_q <= k_q + 1'b1;
				if (take) pick_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (start && !busy) cmd_q <= cmd;
		if (state_q == S_FIT && take) begin
			pick_q     <= k_q;
			pick_gap_q <= gap[k_q];
			pick_lo_q  <= ends[k_q];
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result word shown while busy");

	a_compact: assert property (@(posedge clk) disable iff (!arst_n)
		((used_vec >> 1) & ~used_vec) == '0)
		else $error("used slots not compacted");

	a_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.operation == OP_NONE) |=> ##1 !done)
		else $error("undefined command produced a result");

endmodule

FILE: design/pta_cell.sv
// One slot of the partition table: entry storage, gap before it, grow check.
// Depends on pta_pkg.
module pta_cell import pta_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cell_ctl_t          ctl,
	input  entry_t             left_entry,
	input  entry_t             right_entry,
	input  logic [31:0]        prev_end,
	input  logic               prev_used,
	input  logic [30:0]        disk_bytes,
	input  logic [31:0]        tag,
	input  logic signed [31:0] amt,
	output entry_t             entry,
	output logic [31:0]        end_addr,
	output logic signed [32:0] gap,
	output logic               gap_ok,
	output logic               match,
	output logic               grow_bad,
	output logic               grow_over
);

	logic               used_q;
	logic [30:0]        start_q;
	logic [30:0]        size_q;
	logic [31:0]        name_q;
	logic               ext_q;
	logic [1:0]         fit_q;
	logic [30:0]        hi;
	logic signed [33:0] nsize;
	logic signed [33:0] nend;

	assign entry    = '{used: used_q, start: start_q, size: size_q, name: name_q,
		ext: ext_q, fit: fit_q};
	assign end_addr = {1'b0, start_q} + {1'b0, size_q};
	assign match    = used_q && (name_q == tag);

	// gap runs from the left neighbor's end to this entry's start (or disk end)
	assign hi     = used_q ? start_q : disk_bytes;
	assign gap    = signed'({2'b00, hi}) - signed'({1'b0, prev_end});
	assign gap_ok = prev_used && (gap >= signed'({amt[31], amt}));

	assign nsize     = signed'({3'b000, size_q}) + signed'({{2{amt[31]}}, amt});
	assign nend      = signed'({3'b000, start_q}) + nsize;
	assign grow_bad  = (nsize <= 34'sd0);
	assign grow_over = (right_entry.used && (nend > signed'({3'b000, right_entry.start})))
		|| (nend > signed'({3'b000, disk_bytes}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else begin
			case (ctl.op)
				CELL_LOAD:       used_q <= ctl.load.used;
				CELL_FROM_LEFT:  used_q <= left_entry.used;
				CELL_FROM_RIGHT: used_q <= right_entry.used;
				default:         used_q <= used_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_LOAD: begin
				start_q <= ctl.load.start;
				size_q  <= ctl.load.size;
				name_q  <= ctl.load.name;
				ext_q   <= ctl.load.ext;
				fit_q   <= ctl.load.fit;
			end
			CELL_FROM_LEFT: begin
				start_q <= left_entry.start;
				size_q  <= left_entry.size;
				name_q  <= left_entry.name;
				ext_q   <= left_entry.ext;
				fit_q   <= left_entry.fit;
			end
			CELL_FROM_RIGHT: begin
				start_q <= right_entry.start;
				size_q  <= right_entry.size;
				name_q  <= right_entry.name;
				ext_q   <= right_entry.ext;
				fit_q   <= right_entry.fit;
			end
			CELL_RESIZE: size_q <= nsize[30:0];
			default: ;
		endcase
	end

endmodule

FILE: dv/pta_checker.sv
`timescale 1ns / 1ps
// Watches the command, result and register ports of the allocator, keeps its own copy of
// the partition table and compares each result word against the predicted one. Uses pta_pkg.
module pta_checker import pta_pkg::*; #(
	parameter int SLOTS        = 4,
	parameter int HEADER_BYTES = 136
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  cmd_t        cmd,
	input  logic        done,
	input  result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending
);

	entry_t      parts [SLOTS];
	logic [30:0] disk_size;
	logic [1:0]  policy;
	result_t     want_results [$];

	assign pending = want_results.size();

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t: %s mismatch: got %0d, want %0d", $time, what, got, want);
		fail_count++;
	endtask

	function automatic void push_result(status_t st, logic [30:0] at, int slot);
		result_t r;
		r.status       = st;
		r.placed_start = at;
		r.slot_index   = slot[1:0];
		want_results.insert(want_results.size(), r);
	endfunction

	function automatic int lookup_name(logic [31:0] tag);
		for (int i = 0; i < SLOTS; i++)
			if (parts[i].used && parts[i].name == tag)
				return i;
		return -1;
	endfunction

	function automatic void place_partition(cmd_t c);
		longint amt;
		longint lo;
		longint hi;
		longint gap;
		longint pick_gap;
		longint pick_lo;
		int     n;
		int     exts;
		int     pick;
		amt = longint'(c.amount);
		n = 0;
		exts = 0;
		pick = -1;
		pick_gap = 0;
		pick_lo = 0;
		if (amt <= 0) begin
			push_result(ST_BAD_SIZE, '0, 0);
			return;
		end
		for (int i = 0; i < SLOTS; i++) begin
			if (parts[i].used) begin
				n++;
				if (parts[i].ext)
					exts++;
			end
			if (n == SLOTS) begin
				push_result(ST_FULL, '0, 0);
				return;
			end
			if (exts >= 1 && c.part_kind) begin
				push_result(ST_EXT_TWICE, '0, 0);
				return;
			end
		end
		if (lookup_name(c.name_tag) >= 0) begin
			push_result(ST_NAME_DUP, '0, 0);
			return;
		end
		for (int k = 0; k <= n; k++) begin
			lo = (k == 0) ? longint'(HEADER_BYTES)
				: longint'(parts[k-1].start) + longint'(parts[k-1].size);
			hi = (k == n) ? longint'(disk_size) : longint'(parts[k].start);
			gap = hi - lo;
			if (gap < amt)
				continue;
			if (pick < 0 || (policy == FIT_BEST && gap < pick_gap)
					|| (policy == FIT_WORST && gap > pick_gap)) begin
				pick = k;
				pick_gap = gap;
				pick_lo = lo;
			end
			// policy 3 behaves as first fit
			if (policy != FIT_BEST && policy != FIT_WORST)
				break;
		end
		if (pick < 0) begin
			push_result(ST_NO_SPACE, '0, 0);
			return;
		end
		for (int i = n; i > pick; i--)
			parts[i] = parts[i-1];
		parts[pick].used  = 1'b1;
		parts[pick].start = pick_lo[30:0];
		parts[pick].size  = amt[30:0];
		parts[pick].name  = c.name_tag;
		parts[pick].ext   = c.part_kind;
		parts[pick].fit   = c.fit_tag;
		push_result(ST_OK, parts[pick].start, pick);
	endfunction

	function automatic void resize_partition(cmd_t c);
		int     i;
		longint nsize;
		longint nend;
		i = lookup_name(c.name_tag);
		if (i < 0) begin
			push_result(ST_NOT_FOUND, '0, 0);
			return;
		end
		nsize = longint'(parts[i].size) + longint'(c.amount);
		if (nsize <= 0) begin
			push_result(ST_BAD_SIZE, '0, 0);
			return;
		end
		nend = longint'(parts[i].start) + nsize;
		if ((i + 1 < SLOTS && parts[i+1].used && nend > longint'(parts[i+1].start))
				|| nend > longint'(disk_size)) begin
			push_result(ST_OVER, '0, 0);
			return;
		end
		parts[i].size = nsize[30:0];
		push_result(ST_OK, parts[i].start, i);
	endfunction

	function automatic void remove_partition(cmd_t c);
		int i;
		i = lookup_name(c.name_tag);
		if (i < 0) begin
			push_result(ST_NOT_FOUND, '0, 0);
			return;
		end
		for (int j = i; j + 1 < SLOTS; j++)
			parts[j] = parts[j+1];
		parts[SLOTS-1] = '0;
		push_result(ST_OK, '0, i);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t w;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++)
				parts[i] = '0;
			disk_size = DISK_RESET;
			policy = FIT_BEST;
			want_results.delete();
			fail_count = 0;
		end else begin
			if (done) begin
				if (want_results.size() == 0) begin
					$display("%0t: result word with nothing expected", $time);
					fail_count++;
				end else begin
					w = want_results.pop_front();
					if (result.status != w.status)
						report_mismatch("status", result.status, w.status);
					if (result.placed_start != w.placed_start)
						report_mismatch("placed_start", result.placed_start, w.placed_start);
					if (result.slot_index != w.slot_index)
						report_mismatch("slot_index", result.slot_index, w.slot_index);
				end
			end
			if (start && !busy) begin
				case (cmd.operation)
					OP_CREATE: place_partition(cmd);
					OP_GROW:   resize_partition(cmd);
					OP_DELETE: remove_partition(cmd);
					default:   ;
				endcase
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_FIT)
					policy = pwdata[1:0];
				else
					disk_size = pwdata[30:0];
			end
		end
	end

endmodule

FILE: dv/tb_partition_table_fit_allocator.sv
`timescale 1ns / 1ps
// Stimulus and verdict for partition_table_fit_allocator: directed corner commands, then
// random create/grow/delete/undefined phases under several disk sizes and fit policies. Uses pta_checker.
module tb_partition_table_fit_allocator;
	import pta_pkg::*;

	localparam int    IDLE_MAX  = 20000;
	localparam logic [2:0] ADDR_DISK = {REG_DISK, 2'b00};
	localparam logic [2:0] ADDR_FIT  = {REG_FIT, 2'b00};

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	cmd_t        cmd;
	logic        done;
	result_t     result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          pending;
	int          quiet_cycles = 0;
	logic [31:0] tag_pool [6];
	logic [30:0] cur_disk;
	int          idle_pct;

	partition_table_fit_allocator i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	pta_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .pready(pready),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog: cycles with no word moving on any port
	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_MAX) begin
			$display("tb_partition_table_fit_allocator NOT OK");
			$finish;
		end
	end

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic drain_results();
		while (pending != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic configure(input logic [30:0] disk, input logic [1:0] fit);
		drain_results();
		reg_write(ADDR_DISK, {1'b0, disk});
		reg_write(ADDR_FIT, {30'd0, fit});
		cur_disk = disk;
	endtask

	task automatic send_command(input op_t op, input logic [31:0] tag,
			input logic signed [31:0] amt, input logic kind, input logic [1:0] fit);
		logic was_busy;
		if ($urandom_range(99) < idle_pct)
			repeat ($urandom_range(1, 8)) @(negedge clk);
		else
			@(negedge clk);
		start = 1'b1;
		cmd.operation = op;
		cmd.name_tag = tag;
		cmd.amount = amt;
		cmd.part_kind = kind;
		cmd.fit_tag = fit;
		do begin
			was_busy = busy;
			@(negedge clk);
		end while (was_busy);
		start = 1'b0;
	endtask

	task automatic random_command();
		int          pick;
		int          span;
		logic [31:0] tag;
		pick = $urandom_range(99);
		tag = tag_pool[$urandom_range(5)];
		span = (cur_disk > 31'd20) ? int'(cur_disk / 5) : 4;
		if (pick < 45)
			send_command(OP_CREATE, tag, $urandom_range(1, span),
				($urandom_range(9) == 0), 2'($urandom_range(3)));
		else if (pick < 72)
			send_command(OP_GROW, tag, $signed($urandom_range(0, 2 * span)) - span,
				1'($urandom_range(1)), 2'($urandom_range(3)));
		else if (pick < 90)
			send_command(OP_DELETE, tag, $urandom, 1'($urandom_range(1)),
				2'($urandom_range(3)));
		else
			send_command(op_t'($urandom_range(3)),
				($urandom_range(1) != 0) ? $urandom : tag, $urandom,
				1'($urandom_range(1)), 2'($urandom_range(3)));
	endtask

	initial begin
		logic [30:0] disks [4];
		logic [1:0]  fits [4];
		int          idles [4];
		disks = '{31'd1000, 31'h7FFF_FFFF, DISK_RESET, 31'd600};
		fits = '{FIT_FIRST, FIT_WORST, FIT_BEST, 2'd3};
		idles = '{0, 70, 0, 24};
		tag_pool = '{32'd0, 32'hFFFF_FFFF, $urandom, $urandom, 32'd7, 32'h8000_0001};
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_pct = 0;
		cur_disk = DISK_RESET;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// directed: register defaults first
		send_command(OP_CREATE, 32'd1, 0, 1'b0, FIT_FIRST);
		send_command(OP_CREATE, 32'd1, 32'sh8000_0000, 1'b0, FIT_FIRST);
		send_command(OP_CREATE, 32'd1, 32'sh7FFF_FFFF, 1'b0, FIT_FIRST);
		send_command(OP_CREATE, 32'd0, 1000, 1'b1, FIT_WORST);
		send_command(OP_CREATE, 32'd2, 1000, 1'b1, 2'd3);
		send_command(OP_CREATE, 32'd0, 500, 1'b0, FIT_BEST);
		send_command(OP_CREATE, 32'hFFFF_FFFF, 2000, 1'b0, FIT_BEST);
		send_command(OP_GROW, 32'd9, 10, 1'b0, FIT_FIRST);
		send_command(OP_GROW, 32'd0, -1000, 1'b0, FIT_FIRST);
		send_command(OP_GROW, 32'd0, 1, 1'b0, FIT_FIRST);
		send_command(OP_GROW, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 1'b0, FIT_FIRST);
		send_command(OP_GROW, 32'hFFFF_FFFF, -1999, 1'b0, FIT_FIRST);
		send_command(OP_DELETE, 32'd0, 0, 1'b0, FIT_FIRST);
		send_command(OP_NONE, 32'd5, 5, 1'b1, 2'd3);
		send_command(OP_CREATE, 32'd3, 200, 1'b0, FIT_FIRST);
		send_command(OP_CREATE, 32'd4, 200, 1'b0, FIT_FIRST);
		send_command(OP_CREATE, 32'd5, 200, 1'b0, FIT_FIRST);
		send_command(OP_CREATE, 32'd6, 200, 1'b1, FIT_FIRST);
		send_command(OP_DELETE, 32'd77, 0, 1'b0, FIT_FIRST);
		send_command(OP_DELETE, 32'hFFFF_FFFF, 0, 1'b0, FIT_FIRST);
		// smallest disk: the gap up to the disk end is negative, the others are empty
		configure(31'd1, FIT_FIRST);
		send_command(OP_CREATE, 32'd8, 1, 1'b0, FIT_FIRST);
		send_command(OP_GROW, 32'd3, 1, 1'b0, FIT_FIRST);
		for (int t = 3; t <= 5; t++)
			send_command(OP_DELETE, t, 0, 1'b0, FIT_FIRST);

		for (int p = 0; p < 4; p++) begin
			configure(disks[p], fits[p]);
			idle_pct = idles[p];
			repeat (100) random_command();
		end

		drain_results();
		if (fail_count == 0)
			$display("tb_partition_table_fit_allocator OK");
		else
			$display("tb_partition_table_fit_allocator NOT OK");
		$finish;
	end

endmodule
